[sv/sope_pkg.sv]
// Shared types, codes and table math for the plane wave elevation core.
// No dependencies; imported by sum_of_plane_waves_elevation_core.
`timescale 1ns / 1ps

package sope_pkg;

   localparam int AMP_W      = 16;
   localparam int RATE_W     = 24;
   localparam int COORD_W    = 16;
   localparam int COUNT_W    = 5;
   localparam int ELEV_W     = 20;
   localparam int SINE_W     = 15;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 56;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_COUNT    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_FUNCTION = 8'd1;

   localparam logic [RATE_W-1:0] QUARTER_TURN = 24'h400000;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [AMP_W-1:0] amplitude;
      logic [RATE_W-1:0]       spatial_rate;
      logic [RATE_W-1:0]       temporal_rate;
      logic [RATE_W-1:0]       phase_offset;
   } wave_entry_type;

   // Quarter-wave sine sample in Q0.15, Q30 Taylor series through x^15.
   function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned i,
                                                      input int unsigned tbits);
      longint unsigned x;
      longint unsigned term;
      longint          sum;
      longint          v;
      x    = (longint'(i) * HALF_PI_Q30) >> tbits;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         // divide by (2k)(2k+1)
         case (k)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            5: term = term / 64'd110;
            6: term = term / 64'd156;
            default: term = term / 64'd210;
         endcase
         if ((k % 2) == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = longint'((longint'(sum) * 32768 + (64'd1 << 29)) >> 30);
      if (v > 32767) v = 32767;
      return v[SINE_W-1:0];
   endfunction

endpackage

[sv/sum_of_plane_waves_elevation_core.sv]
// Plane wave elevation core: wave table memory, phase/sine/MAC pipeline, result register.
// Depends on sope_pkg.
`timescale 1ns / 1ps

// Write requests (tuser 0) load one wave into the table.
// Evaluate requests (tuser 1) sum amplitude * sin(phase) over the first
// min(wave_count, MAX_WAVES) entries and return one saturated elevation with
// the time and position echoed. The table memory is read one entry per
// cycle into a five-stage phase, sine lookup and multiply-accumulate
// pipeline. A new request is taken only after the pipeline has drained
// and the result has been loaded into the output register, which waits
// until the previous response there has been taken.
module sum_of_plane_waves_elevation_core #(
   parameter int MAX_WAVES       = 16,
   parameter int SINE_TABLE_BITS = 10,
   parameter int PHASE_BITS      = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // wave_index, amplitude, spatial_rate, temporal_rate, phase_offset,
   // time_index, position_index (low to high), zero padded
   input  logic [sope_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // elevation, echo_time, echo_position (low to high), zero padded
   output logic [sope_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sope_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sope_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sope_pkg::*;

   localparam int AW      = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
   localparam int TBL_N   = 1 << SINE_TABLE_BITS;
   localparam int IDX_W   = SINE_TABLE_BITS + 1;
   localparam int ACC_W   = 37;
   localparam int DROP    = (PHASE_BITS >= RATE_W) ? 0 : RATE_W - PHASE_BITS;
   localparam logic [RATE_W-1:0] PHASE_MASK = ~((24'd1 << DROP) - 24'd1);

   typedef logic [SINE_W-1:0] sine_rom_type [TBL_N+1];

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int i = 0; i <= TBL_N; i++) begin
         rom[i] = quarter_sine(i, SINE_TABLE_BITS);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // request fields
   logic [3:0]              req_wave_index;
   wave_entry_type          req_entry;
   logic [COORD_W-1:0]      req_time;
   logic [COORD_W-1:0]      req_position;

   assign req_wave_index         = req_tdata[3:0];
   assign req_entry.amplitude    = req_tdata[19:4];
   assign req_entry.spatial_rate = req_tdata[43:20];
   assign req_entry.temporal_rate= req_tdata[67:44];
   assign req_entry.phase_offset = req_tdata[91:68];
   assign req_time               = req_tdata[107:92];
   assign req_position           = req_tdata[123:108];

   // configuration
   logic [COUNT_W-1:0] wave_count_ff;
   logic               wave_function_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_count_ff    <= '0;
         wave_function_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WAVE_COUNT:    wave_count_ff    <= csr_wdata[COUNT_W-1:0];
            CSR_WAVE_FUNCTION: wave_function_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // control
   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [COORD_W-1:0] t_ff, x_ff;
   logic               req_fire, eval_fire, mem_we, issue, rsp_load, acc_clear;
   logic               v1_ff, v2_ff, v3_ff, v4_ff, pipe_busy;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign eval_fire  = req_fire && (req_tuser == OP_EVAL);
   assign mem_we     = req_fire && (req_tuser == OP_WRITE)
                       && (32'(req_wave_index) < MAX_WAVES);
   assign pipe_busy  = v1_ff || v2_ff || v3_ff || v4_ff;
   assign n_in       = (32'(wave_count_ff) > MAX_WAVES) ? COUNT_W'(MAX_WAVES)
                                                        : wave_count_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      issue     = 1'b0;
      rsp_load  = 1'b0;
      acc_clear = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (eval_fire) begin
               state_in  = ST_RUN;
               cnt_in    = '0;
               acc_clear = 1'b1;
            end
         end
         ST_RUN: begin
            if (cnt_ff != n_ff) begin
               issue  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_tvalid || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (eval_fire) n_ff <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eval_fire) begin
         t_ff <= req_time;
         x_ff <= req_position;
      end
   end

   // wave table memory
   wave_entry_type       wave_mem [MAX_WAVES];
   wave_entry_type       rd_data_ff;
   logic [AW+3:0]        wr_addr_ext;
   logic [AW+COUNT_W-1:0] rd_addr_ext;
   logic [AW-1:0]        wr_addr, rd_addr;

   assign wr_addr_ext = {{AW{1'b0}}, req_wave_index};
   assign rd_addr_ext = {{AW{1'b0}}, cnt_ff};
   assign wr_addr     = wr_addr_ext[AW-1:0];
   assign rd_addr     = rd_addr_ext[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) wave_mem[wr_addr] <= req_entry;
      if (issue) rd_data_ff <= wave_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage 2: phase products, modulo one turn
   logic [RATE_W-1:0]       prod_s_ff, prod_t_ff, base_ff;
   logic signed [AMP_W-1:0] amp2_ff;

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         prod_s_ff <= RATE_W'(rd_data_ff.spatial_rate * x_ff);
         prod_t_ff <= RATE_W'(rd_data_ff.temporal_rate * t_ff);
         base_ff   <= rd_data_ff.phase_offset
                      + (wave_function_ff ? QUARTER_TURN : '0);
         amp2_ff   <= rd_data_ff.amplitude;
      end
   end

   // stage 3: phase sum, quadrant fold, sine lookup
   logic [RATE_W-1:0]       phase;
   logic [31:0]             phase32;
   logic [1:0]              quad;
   logic [SINE_TABLE_BITS-1:0] tbl_idx;
   logic [IDX_W-1:0]        rom_addr;
   logic [SINE_W-1:0]       sine_ff;
   logic                    neg_ff;
   logic signed [AMP_W-1:0] amp3_ff;

   assign phase    = (prod_s_ff - prod_t_ff + base_ff) & PHASE_MASK;
   assign phase32  = {phase, 8'b0};
   assign quad     = phase32[31:30];
   assign tbl_idx  = phase32[29 -: SINE_TABLE_BITS];
   assign rom_addr = quad[0] ? (IDX_W'(TBL_N) - {1'b0, tbl_idx}) : {1'b0, tbl_idx};

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         sine_ff <= SINE_ROM[rom_addr];
         neg_ff  <= quad[1];
         amp3_ff <= amp2_ff;
      end
   end

   // stage 4: amplitude product
   logic signed [AMP_W-1:0]   sine_s;
   logic signed [2*AMP_W-1:0] prod_ff;

   assign sine_s = neg_ff ? -$signed({1'b0, sine_ff}) : $signed({1'b0, sine_ff});

   always_ff @(posedge clock) begin
      if (v3_ff) prod_ff <= amp3_ff * sine_s;
   end

   // stage 5: accumulate
   logic signed [ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (acc_clear) acc_ff <= '0;
      else if (v4_ff) acc_ff <= acc_ff + ACC_W'(prod_ff);
   end

   // round half up from Q.15 to whole units, saturate
   logic signed [ACC_W-1:0] rounded;
   logic signed [ACC_W-1:0] scaled;
   logic                    in_range;
   logic [ELEV_W-1:0]       elev;

   assign rounded  = acc_ff + ACC_W'(16384);
   assign scaled   = rounded >>> 15;
   assign in_range = (&scaled[ACC_W-1:ELEV_W-1]) || !(|scaled[ACC_W-1:ELEV_W-1]);
   assign elev     = in_range ? scaled[ELEV_W-1:0]
                   : (scaled[ACC_W-1] ? {1'b1, {(ELEV_W-1){1'b0}}}
                                      : {1'b0, {(ELEV_W-1){1'b1}}});

   // response register
   logic                rsp_valid_ff;
   logic [ELEV_W-1:0]   rsp_elev_ff;
   logic [COORD_W-1:0]  rsp_time_ff, rsp_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_elev_ff <= elev;
         rsp_time_ff <= t_ff;
         rsp_pos_ff  <= x_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_pos_ff, rsp_time_ff, rsp_elev_ff};

`ifndef SYNTHESIS
   a_no_write_during_read: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !pipe_busy && !issue)
      else $error("table write while an evaluation reads the table");

   a_drained_at_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> !pipe_busy)
      else $error("result formed before the pipeline drained");

   a_issue_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> cnt_ff <= n_ff)
      else $error("issue counter ran past the wave count");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside the finish state");
`endif

endmodule

[tb/tb_sum_of_plane_waves_elevation_core.sv]
// Testbench for sum_of_plane_waves_elevation_core: directed and random wave table writes and
// point evaluations, each response checked against an in-bench wave sum predictor.
// Depends on sope_pkg and sum_of_plane_waves_elevation_core.
`timescale 1ns / 1ps

module tb_sum_of_plane_waves_elevation_core;
   import sope_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int TBL_BITS     = 10;
   localparam int TBL_SIZE     = 1 << TBL_BITS;
   localparam int DRAIN_CYCLES = 40;
   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 235;
   localparam int NUM_PHASES   = 8;
   localparam int PRINT_CAP    = 50;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LOW  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HIGH = 8'hFF;

   // per phase: wave count, cosine mode, sender idle and receiver stall percentages
   localparam int PHASE_WAVES[NUM_PHASES]   = '{16, 1, 31, 7, 0, 17, 16, 3};
   localparam int PHASE_COSINE[NUM_PHASES]  = '{1, 0, 0, 1, 1, 0, 0, 1};
   localparam int PHASE_SEND_IDLE[NUM_PHASES] = '{0, 84, 0, 13, 0, 0, 84, 13};
   localparam int PHASE_RECV_STALL[NUM_PHASES] = '{0, 0, 84, 13, 0, 84, 0, 13};

   typedef struct {
      logic [ELEV_W-1:0]  elevation;
      logic [COORD_W-1:0] t;
      logic [COORD_W-1:0] x;
   } point_result_type;

   class elevation_scoreboard;
      int                      sine_q[TBL_SIZE+1];
      logic signed [AMP_W-1:0] amp_mem[TABLE_DEPTH];
      logic [RATE_W-1:0]       spatial_mem[TABLE_DEPTH];
      logic [RATE_W-1:0]       temporal_mem[TABLE_DEPTH];
      logic [RATE_W-1:0]       offset_mem[TABLE_DEPTH];
      logic [COUNT_W-1:0]      wave_count;
      logic                    cosine_mode;
      point_result_type        pending[$];
      int                      mismatches;
      int                      evaluations;
      int                      writes;

      function new();
         for (int i = 0; i <= TBL_SIZE; i++) sine_q[i] = quarter_sample(i);
         for (int w = 0; w < TABLE_DEPTH; w++) begin
            amp_mem[w]      = '0;
            spatial_mem[w]  = '0;
            temporal_mem[w] = '0;
            offset_mem[w]   = '0;
         end
         wave_count  = '0;
         cosine_mode = 1'b0;
         mismatches  = 0;
         evaluations = 0;
         writes      = 0;
      endfunction

      // Q1.15 sample of sin(i * pi / (2 * TBL_SIZE)), Q30 Taylor series, truncating products
      function int quarter_sample(int unsigned i);
         longint unsigned angle;
         longint unsigned term;
         longint          acc;
         longint          v;
         angle = (longint'(i) * HALF_PI_Q30) >> TBL_BITS;
         term  = angle;
         acc   = longint'(angle);
         for (int k = 1; k <= 7; k++) begin
            term = (term * angle) >> 30;
            term = (term * angle) >> 30;
            term = term / longint'(4 * k * k + 2 * k);
            if ((k % 2) == 1) acc -= longint'(term);
            else acc += longint'(term);
         end
         if (acc < 0) acc = 0;
         v = (acc * 32768 + (longint'(1) << 29)) >>> 30;
         if (v > 32767) v = 32767;
         return int'(v);
      endfunction

      function int wave_sine(logic [RATE_W-1:0] phase);
         logic [1:0]  quadrant;
         int unsigned slot;
         quadrant = phase[RATE_W-1 -: 2];
         slot     = phase[RATE_W-3 -: TBL_BITS];
         if (quadrant[0]) slot = TBL_SIZE - slot;
         return quadrant[1] ? -sine_q[slot] : sine_q[slot];
      endfunction

      function void report(string msg);
         mismatches++;
         // cap the log; every mismatch still counts
         if (mismatches <= PRINT_CAP) $display("mismatch: %s", msg);
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_WAVE_COUNT) wave_count = val[COUNT_W-1:0];
         else if (idx == CSR_WAVE_FUNCTION) cosine_mode = val[0];
      endfunction

      function void note_request(logic op, logic [REQ_DATA_W-1:0] data);
         logic [3:0]         slot;
         logic [COORD_W-1:0] t;
         logic [COORD_W-1:0] x;
         logic [RATE_W-1:0]  phase;
         longint             acc;
         longint             e;
         int                 n;
         point_result_type   r;
         slot = data[3:0];
         if (op == OP_WRITE) begin
            amp_mem[slot]      = data[19:4];
            spatial_mem[slot]  = data[43:20];
            temporal_mem[slot] = data[67:44];
            offset_mem[slot]   = data[91:68];
            writes++;
            return;
         end
         t   = data[107:92];
         x   = data[123:108];
         n   = (wave_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(wave_count);
         acc = 0;
         for (int w = 0; w < n; w++) begin
            // phase wraps modulo one turn in the 24-bit context
            phase = spatial_mem[w] * x - temporal_mem[w] * t + offset_mem[w]
                    + (cosine_mode ? QUARTER_TURN : '0);
            acc += longint'(amp_mem[w]) * wave_sine(phase);
         end
         e = (acc + 16384) >>> 15;
         if (e > 524287) e = 524287;
         else if (e < -524288) e = -524288;
         r.elevation = e[ELEV_W-1:0];
         r.t         = t;
         r.x         = x;
         pending.push_back(r);
         evaluations++;
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         point_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("response with no evaluation pending, tdata %h", data));
            return;
         end
         want = pending.pop_front();
         if (data[19:0] !== want.elevation)
            report($sformatf("elevation %h, want %h (t %h x %h)", data[19:0],
                             want.elevation, want.t, want.x));
         if (data[35:20] !== want.t)
            report($sformatf("echo_time %h, want %h", data[35:20], want.t));
         if (data[51:36] !== want.x)
            report($sformatf("echo_position %h, want %h", data[51:36], want.x));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = OP_WRITE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   elevation_scoreboard sb;
   int                  sender_idle_pct = 0;
   int                  receiver_stall_pct = 0;
   bit                  hold_request = 1'b0;
   int                  settings_applied = 0;

   sum_of_plane_waves_elevation_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [REQ_DATA_W-1:0] pack_request(
      logic [3:0] slot, logic [AMP_W-1:0] amp, logic [RATE_W-1:0] sr,
      logic [RATE_W-1:0] tr, logic [RATE_W-1:0] po, logic [COORD_W-1:0] t,
      logic [COORD_W-1:0] x);
      return {4'b0, x, t, po, tr, sr, amp, slot};
   endfunction

   task automatic send_request(logic op, logic [REQ_DATA_W-1:0] data);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, data);
   endtask

   task automatic eval_point(logic [COORD_W-1:0] t, logic [COORD_W-1:0] x);
      send_request(OP_EVAL, pack_request('0, '0, '0, '0, '0, t, x));
   endtask

   // Leaves csr_valid high; the caller drops it after its last write.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, val);
   endtask

   task automatic configure(int count, int cosine, bit touch_unmapped);
      write_register(CSR_WAVE_COUNT, 8'(count));
      write_register(CSR_WAVE_FUNCTION, 8'(cosine));
      if (touch_unmapped) begin
         write_register(CSR_UNMAPPED_LOW, 8'hFF);
         write_register(CSR_UNMAPPED_HIGH, 8'($urandom));
      end
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Drop valid, wait for every evaluation to return, then let the pipeline settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_request();
      logic [3:0]         slot;
      logic [AMP_W-1:0]   amp;
      logic [RATE_W-1:0]  sr;
      logic [RATE_W-1:0]  tr;
      logic [RATE_W-1:0]  po;
      logic [COORD_W-1:0] t;
      logic [COORD_W-1:0] x;
      slot = 4'($urandom_range(0, TABLE_DEPTH - 1));
      amp  = 16'($urandom);
      sr   = 24'($urandom);
      tr   = 24'($urandom);
      po   = 24'($urandom);
      t    = 16'($urandom);
      x    = 16'($urandom);
      case ($urandom_range(0, 9))
         0: amp = 16'h8000;
         1: amp = 16'h7FFF;
         2: sr = 24'($urandom_range(0, 255));
         default: ;
      endcase
      if ($urandom_range(0, 9) == 0) t = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 9) == 0) x = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 99) < 70) send_request(OP_EVAL, pack_request(slot, amp, sr, tr, po, t, x));
      else send_request(OP_WRITE, pack_request(slot, amp, sr, tr, po, t, x));
   endtask

   initial begin : response_sink
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [AMP_W-1:0]  amp;
      logic [RATE_W-1:0] sr;
      logic [RATE_W-1:0] tr;
      logic [RATE_W-1:0] po;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero waves: every evaluation sums nothing
      configure(0, 0, 1'b0);
      eval_point('0, '0);
      eval_point('1, '1);

      // fill the whole table; first entries sit on quadrant edges and field extremes
      for (int w = 0; w < TABLE_DEPTH; w++) begin
         amp = 16'($urandom);
         sr  = 24'($urandom);
         tr  = 24'($urandom);
         po  = 24'($urandom);
         case (w)
            0: begin amp = 16'h7FFF; sr = '0; tr = '0; po = '0; end
            1: begin amp = 16'h8000; sr = '0; tr = '0; po = QUARTER_TURN; end
            2: begin amp = 16'h7FFF; sr = '0; tr = '0; po = 24'h800000; end
            3: begin amp = 16'h8000; sr = '0; tr = '0; po = 24'hC00000; end
            4: begin amp = 16'hFFFF; sr = '1; tr = '1; po = '1; end
            5: begin amp = 16'h0001; sr = 24'd1; tr = 24'd1; po = '0; end
            default: ;
         endcase
         send_request(OP_WRITE, pack_request(4'(w), amp, sr, tr, po, '0, '0));
      end
      eval_point(16'h1234, 16'h5678);
      drain();

      // full table, sine mode; unmapped register indexes must be ignored
      configure(TABLE_DEPTH, 0, 1'b1);
      eval_point('0, '0);
      eval_point('1, '1);
      eval_point(16'd0, 16'd1);
      eval_point(16'd1, 16'd0);
      eval_point(16'h8000, 16'h8000);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         configure(PHASE_WAVES[p], PHASE_COSINE[p], p == 3);
         sender_idle_pct    = PHASE_SEND_IDLE[p];
         receiver_stall_pct = PHASE_RECV_STALL[p];
         // back up the pipeline: long response hold while requests keep coming
         if (p == 0) hold_request = 1'b1;
         repeat (PHASE_ITEMS) random_request();
         drain();
      end

      if (sb.pending.size() != 0)
         sb.report($sformatf("%0d evaluations never answered", sb.pending.size()));
      $display("summary: %0d evaluations and %0d table writes under %0d register settings",
               sb.evaluations, sb.writes, settings_applied);
      $display("summary: %0d mismatches", sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/sope_pkg.sv
sv/sum_of_plane_waves_elevation_core.sv
tb/tb_sum_of_plane_waves_elevation_core.sv
